FILE: sv/acm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_pkg
// Shared types and constants for the ascii command to midi converter.
// ----------------------------------------------------------------------------
package acm_pkg;

    // message character codes
    localparam logic [7:0] DIGIT_BASE   = 8'd48;
    localparam logic [7:0] LETTER_O     = 8'h4F;
    localparam logic [7:0] LETTER_F     = 8'h46;
    localparam logic [7:0] LETTER_P     = 8'h50;
    localparam logic [7:0] LETTER_C     = 8'h43;
    localparam logic [7:0] LETTER_B     = 8'h42;
    localparam logic [7:0] LETTER_R     = 8'h52;
    localparam logic [7:0] LETTER_H     = 8'h48;

    // midi status bases
    localparam logic [7:0] STATUS_NOTE_ON   = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF  = 8'h80;
    localparam logic [7:0] STATUS_POLY_AT   = 8'hA0;
    localparam logic [7:0] STATUS_CTRL      = 8'hB0;
    localparam logic [7:0] STATUS_BEND      = 8'hE0;
    localparam logic [7:0] STATUS_PROGRAM   = 8'hC0;
    localparam logic [7:0] STATUS_CHAN_AT   = 8'hD0;

    // command lengths and count limit
    localparam logic [3:0] LEN_THREE_FIELD = 4'd9;
    localparam logic [3:0] LEN_TWO_FIELD   = 4'd6;
    localparam logic [3:0] COUNT_MAX       = 4'd15;

    // message queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        MSG_REJECT = 2'd0,
        MSG_TWO    = 2'd1,
        MSG_THREE  = 2'd2
    } msg_kind_t;

    typedef struct packed {
        msg_kind_t  kind;
        logic [7:0] status;
        logic [7:0] first_param;
        logic [7:0] second_param;
    } msg_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: sv/acm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_front
// Takes command characters, accumulates the fields and classifies the command
// on the end-of-message character.
// ----------------------------------------------------------------------------
module acm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    char_byte,
    input  logic          end_of_message,
    input  acm_pkg::q_status_t q_status,
    output logic          push,
    output acm_pkg::msg_t push_msg
);
    import acm_pkg::*;

    logic [3:0] count_reg, count_next;
    logic [7:0] kind_letter_reg, kind_letter_next;
    logic [7:0] channel_acc_reg, channel_acc_next;
    logic [7:0] first_acc_reg, first_acc_next;
    logic [7:0] second_acc_reg, second_acc_next;

    logic       accept;
    logic [3:0] count_sat;
    logic [7:0] letter_cur, chan_cur, first_cur, second_cur;
    logic [7:0] base;
    logic [3:0] need;

    function automatic logic [7:0] acc_digit(input logic [7:0] acc, input logic [7:0] c);
        logic [7:0] d;
        d = c - DIGIT_BASE;
        return (acc << 3) + (acc << 1) + d;
    endfunction

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        letter_cur = kind_letter_reg;
        chan_cur   = channel_acc_reg;
        first_cur  = first_acc_reg;
        second_cur = second_acc_reg;
        if (count_reg == 4'd0)
        begin
            letter_cur = char_byte;
        end
        else if (count_reg inside {[4'd1:4'd2]})
        begin
            chan_cur = acc_digit(channel_acc_reg, char_byte);
        end
        else if (count_reg inside {[4'd3:4'd5]})
        begin
            first_cur = acc_digit(first_acc_reg, char_byte);
        end
        else if (count_reg inside {[4'd6:4'd8]})
        begin
            second_cur = acc_digit(second_acc_reg, char_byte);
        end
        count_sat = (count_reg == COUNT_MAX) ? count_reg : count_reg + 4'd1;

        // letter decode
        need = LEN_THREE_FIELD;
        case (letter_cur)
            LETTER_O: base = STATUS_NOTE_ON;
            LETTER_F: base = STATUS_NOTE_OFF;
            LETTER_P: base = STATUS_POLY_AT;
            LETTER_C: base = STATUS_CTRL;
            LETTER_B: base = STATUS_BEND;
            LETTER_R:
            begin
                base = STATUS_PROGRAM;
                need = LEN_TWO_FIELD;
            end
            LETTER_H:
            begin
                base = STATUS_CHAN_AT;
                need = LEN_TWO_FIELD;
            end
            default:  base = 8'd0;
        endcase

        push_msg.status       = base + chan_cur - 8'd1;
        push_msg.first_param  = first_cur;
        push_msg.second_param = second_cur;
        if (base == 8'd0 || count_sat != need)
        begin
            push_msg.kind = MSG_REJECT;
        end
        else if (need == LEN_TWO_FIELD)
        begin
            push_msg.kind = MSG_TWO;
        end
        else
        begin
            push_msg.kind = MSG_THREE;
        end

        push = accept && end_of_message;

        count_next       = count_reg;
        kind_letter_next = kind_letter_reg;
        channel_acc_next = channel_acc_reg;
        first_acc_next   = first_acc_reg;
        second_acc_next  = second_acc_reg;
        if (accept)
        begin
            if (end_of_message)
            begin
                count_next       = 4'd0;
                kind_letter_next = 8'd0;
                channel_acc_next = 8'd0;
                first_acc_next   = 8'd0;
                second_acc_next  = 8'd0;
            end
            else
            begin
                count_next       = count_sat;
                kind_letter_next = letter_cur;
                channel_acc_next = chan_cur;
                first_acc_next   = first_cur;
                second_acc_next  = second_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= 4'd0;
            kind_letter_reg <= 8'd0;
            channel_acc_reg <= 8'd0;
            first_acc_reg   <= 8'd0;
            second_acc_reg  <= 8'd0;
        end
        else
        begin
            count_reg       <= count_next;
            kind_letter_reg <= kind_letter_next;
            channel_acc_reg <= channel_acc_next;
            first_acc_reg   <= first_acc_next;
            second_acc_reg  <= second_acc_next;
        end
    end

endmodule

FILE: sv/acm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_fifo
// Small flop-based queue of classified messages between front and back.
// ----------------------------------------------------------------------------
module acm_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  acm_pkg::msg_t push_msg,
    input  logic          pop,
    output acm_pkg::msg_t head_msg,
    output acm_pkg::q_status_t q_status
);
    import acm_pkg::*;

    msg_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign head_msg       = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_msg;
        end
    end

    // no overflow or underflow
    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_status.full))
        else $error("message queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !(pop && q_status.empty))
        else $error("message queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("queue count missed a push");

endmodule

FILE: sv/acm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acm_back
// Walks the message at the head of the queue and emits its midi bytes
// through an output register.
// ----------------------------------------------------------------------------
module acm_back (
    input  logic          clk,
    input  logic          rst_n,
    input  acm_pkg::msg_t head_msg,
    input  acm_pkg::q_status_t q_status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    midi_byte,
    output logic          last_of_run,
    output logic          rejected
);
    import acm_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       rej_reg, rej_next;
    logic       load;
    logic [7:0] sel_byte;
    logic       sel_last;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = (head_msg.kind == MSG_REJECT) ? 8'd0 : head_msg.status;
            2'd1:    sel_byte = head_msg.first_param;
            default: sel_byte = head_msg.second_param;
        endcase
        sel_last = (head_msg.kind == MSG_REJECT)
                || (head_msg.kind == MSG_TWO && idx_reg == 2'd1)
                || (head_msg.kind == MSG_THREE && idx_reg == 2'd2);

        load = !out_valid_reg || !out_stall;
        pop  = load && !q_status.empty && sel_last;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        rej_next       = rej_reg;
        if (load)
        begin
            out_valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                byte_next = sel_byte;
                last_next = sel_last;
                rej_next  = (head_msg.kind == MSG_REJECT);
                idx_next  = sel_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        rej_reg  <= rej_next;
    end

    assign out_valid   = out_valid_reg;
    assign midi_byte   = byte_reg;
    assign last_of_run = last_reg;
    assign rejected    = rej_reg;

    // a partly sent message stays at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> !q_status.empty)
        else $error("message in progress left the queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg == 2'd2) |-> (head_msg.kind == MSG_THREE))
        else $error("third byte on a short message");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rej_reg) |-> (last_reg && byte_reg == 8'd0))
        else $error("rejection not a single zero byte");

endmodule

FILE: sv/ascii_command_to_midi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_command_to_midi_core
// Turns a text command, one character per transaction, into a midi message.
// ----------------------------------------------------------------------------
// path: the front classifies the message into the queue when the closing
//   character is accepted; the back then loads its first byte from the queue
//   head into the output register, which out_stall can hold
// throughput: one character per cycle in, one midi byte per cycle out while
//   out_stall is low; the input stalls only while the four-entry message queue is full
// reset: rst_n clears the character count, accumulators, queue pointers and
//   output valid at once; no clearing pass is needed
module ascii_command_to_midi_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_byte,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] midi_byte,
    output logic       last_of_run,
    output logic       rejected
);
    import acm_pkg::*;

    // front to queue
    logic      push;
    msg_t      push_msg;
    // queue to back
    logic      pop;
    msg_t      head_msg;
    q_status_t q_status;

    // front: accumulates letter, channel and parameters, classifies on the
    // end-of-message character and pushes one message descriptor
    acm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_byte      (char_byte),
        .end_of_message (end_of_message),
        .q_status       (q_status),
        .push           (push),
        .push_msg       (push_msg)
    );

    // queue decouples character intake from byte output
    acm_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_msg (push_msg),
        .pop      (pop),
        .head_msg (head_msg),
        .q_status (q_status)
    );

    // back: sends one, two or three bytes per message, one per transaction
    acm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_msg    (head_msg),
        .q_status    (q_status),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .midi_byte   (midi_byte),
        .last_of_run (last_of_run),
        .rejected    (rejected)
    );

endmodule
